### design/crc8_fixed_packet_deframer_core_defines.svh
// Assertion macros shared by the deframer RTL.
// Depends on a clock named clk and a reset named rst in the using module.
`ifndef CRC8_FIXED_PACKET_DEFRAMER_CORE_DEFINES_SVH
`define CRC8_FIXED_PACKET_DEFRAMER_CORE_DEFINES_SVH

// Same-cycle implication.
`define C8DF_ASSERT_IMPL(label, lhs, rhs, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (lhs) |-> (rhs)) else $error(msg);

// Next-cycle implication.
`define C8DF_ASSERT_NEXT(label, lhs, rhs, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (lhs) |=> (rhs)) else $error(msg);

`endif

### design/c8df_pkg.sv
// Shared types and constants for the CRC-8 packet deframer.
// No dependencies; used by the controller, datapath and top level.
package c8df_pkg;

  localparam int BYTE_W    = 8;
  localparam int FAIL_W    = 16;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_W     = 8;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_CRC_CHECK_ENABLE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HEADER_VALUE     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_VERSION_VALUE    = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CRC_POLYNOMIAL   = 2'd3;

  // reset values of the configuration registers
  localparam logic              RST_CRC_CHECK_ENABLE = 1'b1;
  localparam logic [BYTE_W-1:0] RST_HEADER_VALUE     = 8'd84;
  localparam logic [BYTE_W-1:0] RST_VERSION_VALUE    = 8'd44;
  localparam logic [BYTE_W-1:0] RST_CRC_POLYNOMIAL   = 8'd77;

  localparam logic [FAIL_W-1:0] FAIL_MAX = '1;

  // controller to datapath
  typedef struct packed {
    logic take_byte;    // input word accepted this cycle
    logic rd_issue;     // read packet store at replay address
    logic load_replay;  // load output register from store read data
    logic load_err;     // load output register with the error word
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic final_byte;   // the offered byte would close the packet
    logic pkt_ok;       // CRC matches or checking is off
    logic rd_last;      // replay address points at the last entry
  } stat_t;

endpackage

### design/c8df_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module c8df_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 47
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### design/c8df_datapath.sv
// Datapath: config registers, framing position, running CRC, failure counter,
// packet store and output register. Depends on c8df_pkg and c8df_ram.
module c8df_datapath #(
  parameter int PACKET_LEN = 47
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [c8df_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [c8df_pkg::CFG_W-1:0]     cfg_data,
  input  logic [c8df_pkg::BYTE_W-1:0]    rx_byte,
  input  c8df_pkg::cmd_t                 cmd,
  output c8df_pkg::stat_t                stat,
  output logic [c8df_pkg::BYTE_W-1:0]    packet_byte,
  output logic                           end_of_packet,
  output logic                           crc_error,
  output logic [c8df_pkg::FAIL_W-1:0]    fail_count
);

  localparam int POS_W = $clog2(PACKET_LEN);
  localparam logic [POS_W-1:0] POS_LAST = POS_W'(PACKET_LEN - 1);
  localparam logic [POS_W-1:0] POS_ONE  = POS_W'(1);

  logic                        crc_check_enable;
  logic [c8df_pkg::BYTE_W-1:0] header_value;
  logic [c8df_pkg::BYTE_W-1:0] version_value;
  logic [c8df_pkg::BYTE_W-1:0] crc_polynomial;

  logic [POS_W-1:0]            byte_position;
  logic [c8df_pkg::BYTE_W-1:0] running_crc;
  logic [c8df_pkg::FAIL_W-1:0] failure_counter;
  logic [c8df_pkg::BYTE_W-1:0] err_byte;
  logic [POS_W-1:0]            rd_addr;

  logic                        byte_kept;
  logic                        store_we;
  logic [c8df_pkg::BYTE_W-1:0] crc_next;
  logic [c8df_pkg::BYTE_W-1:0] ram_rdata;

  function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] d,
                                           input logic [7:0] poly);
    logic [7:0] c;
    c = crc ^ d;
    for (int b = 0; b < 8; b++) begin
      c = c[7] ? ((c << 1) ^ poly) : (c << 1);
    end
    return c;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      crc_check_enable <= c8df_pkg::RST_CRC_CHECK_ENABLE;
      header_value     <= c8df_pkg::RST_HEADER_VALUE;
      version_value    <= c8df_pkg::RST_VERSION_VALUE;
      crc_polynomial   <= c8df_pkg::RST_CRC_POLYNOMIAL;
    end else if (cfg_we) begin
      case (cfg_index)
        c8df_pkg::REG_CRC_CHECK_ENABLE: crc_check_enable <= cfg_data[0];
        c8df_pkg::REG_HEADER_VALUE:     header_value     <= cfg_data;
        c8df_pkg::REG_VERSION_VALUE:    version_value    <= cfg_data;
        c8df_pkg::REG_CRC_POLYNOMIAL:   crc_polynomial   <= cfg_data;
        default: ;
      endcase
    end
  end

  // drop a non-header byte while hunting, and a wrong version byte at position one
  always_comb begin
    byte_kept = 1'b1;
    if (byte_position == '0 && rx_byte != header_value) begin
      byte_kept = 1'b0;
    end
    if (byte_position == POS_ONE && rx_byte != version_value) begin
      byte_kept = 1'b0;
    end
  end

  assign store_we = cmd.take_byte && byte_kept;
  assign crc_next = crc8_step(running_crc, rx_byte, crc_polynomial);

  assign stat.final_byte = (byte_position == POS_LAST);
  assign stat.pkt_ok     = !crc_check_enable || (running_crc == rx_byte);
  assign stat.rd_last    = (rd_addr == POS_LAST);

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position   <= '0;
      running_crc     <= '0;
      failure_counter <= '0;
    end else if (store_we) begin
      if (byte_position != POS_LAST) begin
        byte_position <= byte_position + POS_ONE;
        running_crc   <= crc_next;
      end else begin
        byte_position <= '0;
        running_crc   <= '0;
        if (!stat.pkt_ok && failure_counter != c8df_pkg::FAIL_MAX) begin
          failure_counter <= failure_counter + 1'b1;
        end
      end
    end
  end

  // hold the received CRC byte for the error word
  always_ff @(posedge clk) begin
    if (store_we) begin
      err_byte <= rx_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_addr <= '0;
    end else if (cmd.load_replay) begin
      rd_addr <= stat.rd_last ? '0 : rd_addr + POS_ONE;
    end
  end

  c8df_ram #(
    .WIDTH (c8df_pkg::BYTE_W),
    .DEPTH (PACKET_LEN)
  ) u_store (
    .clk   (clk),
    .we    (store_we),
    .waddr (byte_position),
    .wdata (rx_byte),
    .re    (cmd.rd_issue),
    .raddr (rd_addr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (cmd.load_replay) begin
      packet_byte   <= ram_rdata;
      end_of_packet <= stat.rd_last;
      crc_error     <= 1'b0;
      fail_count    <= failure_counter;
    end else if (cmd.load_err) begin
      packet_byte   <= err_byte;
      end_of_packet <= 1'b1;
      crc_error     <= 1'b1;
      fail_count    <= failure_counter;
    end
  end

endmodule

### design/c8df_ctrl.sv
// Controller: input acceptance, replay sequencing and output valid.
// Depends on c8df_pkg and crc8_fixed_packet_deframer_core_defines.svh.
`include "crc8_fixed_packet_deframer_core_defines.svh"

module c8df_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  output logic            out_valid,
  input  logic            out_ready,
  input  c8df_pkg::stat_t stat,
  output c8df_pkg::cmd_t  cmd
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RD   = 2'd1;
  localparam logic [1:0] ST_LD   = 2'd2;
  localparam logic [1:0] ST_ERR  = 2'd3;

  logic [1:0] state;
  logic [1:0] state_next;
  logic       out_free;

  assign out_free = !out_valid || out_ready;
  assign in_ready = (state == ST_IDLE);

  always_comb begin
    state_next      = state;
    cmd             = '0;
    cmd.take_byte   = in_valid && in_ready;
    case (state)
      ST_IDLE: begin
        if (in_valid && stat.final_byte) begin
          state_next = stat.pkt_ok ? ST_RD : ST_ERR;
        end
      end
      ST_RD: begin
        cmd.rd_issue = 1'b1;
        state_next   = ST_LD;
      end
      ST_LD: begin
        // read data holds until the output register frees up
        if (out_free) begin
          cmd.load_replay = 1'b1;
          state_next      = stat.rd_last ? ST_IDLE : ST_RD;
        end
      end
      ST_ERR: begin
        if (out_free) begin
          cmd.load_err = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.load_replay || cmd.load_err) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  `C8DF_ASSERT_IMPL(a_load_when_free, cmd.load_replay || cmd.load_err, !out_valid || out_ready, "output word overwritten while stalled")
  `C8DF_ASSERT_NEXT(a_final_starts_emit, in_valid && in_ready && stat.final_byte, state == ST_RD || state == ST_ERR, "final byte did not start emission")
  `C8DF_ASSERT_NEXT(a_replay_ends_idle, cmd.load_replay && stat.rd_last, state == ST_IDLE && out_valid, "replay did not end after last entry")
  `C8DF_ASSERT_IMPL(a_single_load, cmd.load_err, !cmd.load_replay && !cmd.take_byte, "error word loaded alongside other work")

endmodule

### design/crc8_fixed_packet_deframer_core.sv
// Fixed-length packet deframer with CRC-8 check: byte stream in, packet stream out.
// Input s_* takes one received byte per word; output m_* replays packets.
// Config port: cfg_we/cfg_index/cfg_data, to be written only while idle; the block
// itself does not enforce this. After a good packet's final byte is accepted, the
// packet is replayed from the store, each byte by a store read and then an output
// load. A bad packet gives one error word in place of the replay.
// Throughput: one input byte per cycle while framing; s_tready is low while a
// packet or error word is being emitted. The last output word may wait in the
// output register while new bytes come in.
// Reset clears the framing position, running CRC, failure counter and output
// valid and loads the config registers with their reset values; the packet store
// needs no clearing since every entry is written before it is replayed.
// When m_tready is low the output word holds and replay pauses.
// Depends on c8df_pkg, c8df_ctrl, c8df_datapath and c8df_ram.
module crc8_fixed_packet_deframer_core #(
  parameter int PACKET_LEN = 47
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [c8df_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [c8df_pkg::CFG_W-1:0]     cfg_data,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [7:0]                     s_tdata,  // [7:0] rx_byte
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [23:0]                    m_tdata,  // [7:0] packet_byte, [23:8] fail_count
  output logic                           m_tlast,  // end_of_packet
  output logic                           m_tuser   // crc_error
);

  c8df_pkg::cmd_t  cmd;
  c8df_pkg::stat_t stat;

  c8df_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  c8df_datapath #(
    .PACKET_LEN (PACKET_LEN)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .rx_byte       (s_tdata),
    .cmd           (cmd),
    .stat          (stat),
    .packet_byte   (m_tdata[7:0]),
    .end_of_packet (m_tlast),
    .crc_error     (m_tuser),
    .fail_count    (m_tdata[23:8])
  );

endmodule
